FILE: hdl/keyed_shift_register_hash_top_macros.svh
// assertion helpers shared by the hash block
`ifndef KEYED_SHIFT_REGISTER_HASH_TOP_MACROS_SVH
`define KEYED_SHIFT_REGISTER_HASH_TOP_MACROS_SVH

// checked on clk_i, quiet while rst_ni is low
`define KSRH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on clk_i at every edge, reset included
`define KSRH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/ksrh_pkg.sv
package ksrh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RoundW = 8;

  // mixing round constants
  localparam logic [WordW-1:0] MixAddA  = 32'd14921776;
  localparam logic [WordW-1:0] MixMulA  = 32'd17761492;
  localparam logic [WordW-1:0] MixXorA  = 32'h0582_7066;
  localparam logic [WordW-1:0] MixAddB  = 32'h0002_c357;
  localparam logic [WordW-1:0] MixXorB  = 32'd10661688;
  localparam logic [WordW-1:0] MixMask  = 32'h8000_0002;
  localparam logic [WordW-1:0] MixAgain = 32'h0000_0002;

  // last round index before the round cap
  localparam logic [RoundW-1:0] RoundLast = '1;

  typedef struct packed {
    logic start;
  } mix_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mix_stat_t;

endpackage

FILE: hdl/ksrh_if.sv
interface ksrh_in_if;
  logic                        valid;
  logic                        ready;
  logic                        restart;
  logic [ksrh_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, output restart, output data_byte, input ready);
  modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

interface ksrh_out_if;
  logic                        valid;
  logic                        ready;
  logic [ksrh_pkg::WordW-1:0]  digest;

  modport source (output valid, output digest, input ready);
  modport sink   (input valid, input digest, output ready);
endinterface

FILE: hdl/ksrh_mix.sv
module ksrh_mix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ksrh_pkg::mix_ctrl_t        ctrl_i,
  input  logic [ksrh_pkg::WordW-1:0] value_i,
  output ksrh_pkg::mix_stat_t        stat_o,
  output logic [ksrh_pkg::WordW-1:0] result_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_HALF_A = 2'd1;
  localparam logic [1:0] M_HALF_B = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [ksrh_pkg::WordW-1:0]    v_q, v_d;
  logic [ksrh_pkg::RoundW-1:0]   cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [ksrh_pkg::WordW-1:0]    op_b, prod, sum_b, mixed_b;
  logic                          again;

  // the one shared multiplier, second operand picked by round half
  always_comb begin
    if (state_q == M_HALF_A) begin
      op_b = ksrh_pkg::MixMulA + v_q;
    end else begin
      op_b = ksrh_pkg::MixXorB ^ v_q;
    end
  end

  assign prod    = v_q * op_b;
  assign sum_b   = v_q + ksrh_pkg::MixAddB + prod;
  assign mixed_b = sum_b ^ (sum_b >> 16);
  assign again   = ((mixed_b & ksrh_pkg::MixMask) == ksrh_pkg::MixAgain)
                   && (cnt_q != ksrh_pkg::RoundLast);

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      M_IDLE: begin
        if (ctrl_i.start) begin
          v_d     = value_i;
          cnt_d   = '0;
          state_d = M_HALF_A;
        end
      end
      M_HALF_A: begin
        v_d     = (v_q + ksrh_pkg::MixAddA + prod) ^ ksrh_pkg::MixXorA;
        state_d = M_HALF_B;
      end
      M_HALF_B: begin
        v_d   = mixed_b;
        cnt_d = cnt_q + 1'b1;
        if (again) begin
          state_d = M_HALF_A;
        end else begin
          state_d = M_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign stat_o.busy = (state_q != M_IDLE);
  assign stat_o.done = done_q;
  assign result_o    = v_q;

endmodule

FILE: hdl/keyed_shift_register_hash_top.sv
// Byte-serial keyed hash over a ring of RING_WORDS 32-bit words. Each
// request carries one message byte and a restart flag; restart empties the
// ring and returns the pointer to word zero before that byte is absorbed.
// The byte plus the current word is run through a mixing function, the
// mixed value is added into the next word and the pointer moves on; the
// response digest is the xor of the new current and next words. Each
// byte steps through RDC, INIT, MIX, ADD, RDN and OUT until its digest
// is loaded into the output register; MIX runs R mixing rounds (at least
// one, at most 256, data dependent), each made of two half-rounds. The
// sequencer returns to idle as that digest is loaded, and a new request
// is taken only then, so back to back bytes never overlap. This pace is
// set by the single 32x32 multiplier, which serves both half-rounds one
// after the other, and by the single read port of the ring memory. When
// the previous digest has not been taken yet, the last step waits for it.
// A new byte is taken once the block is back at idle, even while the
// previous digest still waits in the output register.
`include "keyed_shift_register_hash_top_macros.svh"

module keyed_shift_register_hash_top #(
  parameter int unsigned RING_WORDS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ksrh_in_if.sink     in_i,
  ksrh_out_if.source  out_o
);

  localparam int unsigned PtrW = $clog2(RING_WORDS);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(RING_WORDS - 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDC  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_RDN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == LastIdx) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  logic [2:0]                   state_q, state_d;
  logic [PtrW-1:0]              ptr_q, ptr_d;
  logic [PtrW-1:0]              cur_q, cur_d;
  logic [PtrW-1:0]              nxt_q, nxt_d;
  logic [PtrW-1:0]              nxt2;
  logic [RING_WORDS-1:0]        valid_q, valid_d;
  logic [ksrh_pkg::ByteW-1:0]   byte_q, byte_d;
  logic [ksrh_pkg::WordW-1:0]   sum_q, sum_d;
  logic                         out_valid_q, out_valid_d;
  logic [ksrh_pkg::WordW-1:0]   digest_q, digest_d;

  // ring storage, one write and one registered read port
  logic [ksrh_pkg::WordW-1:0]   mem [RING_WORDS];
  logic [ksrh_pkg::WordW-1:0]   rd_q;
  logic                         rd_ok_q;
  logic                         rd_en;
  logic [PtrW-1:0]              rd_addr;
  logic [ksrh_pkg::WordW-1:0]   rd_word;
  logic                         wr_en;

  ksrh_pkg::mix_ctrl_t          mix_ctrl;
  ksrh_pkg::mix_stat_t          mix_stat;
  logic [ksrh_pkg::WordW-1:0]   mix_result;
  logic [ksrh_pkg::WordW-1:0]   mix_seed;

  logic                         in_fire;
  logic                         out_free;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign nxt2     = ring_next(nxt_q);

  // words never written since the last clear read as zero
  assign rd_word  = rd_ok_q ? rd_q : '0;
  assign mix_seed = {{(ksrh_pkg::WordW - ksrh_pkg::ByteW){1'b0}}, byte_q} + rd_word;

  always_comb begin
    state_d        = state_q;
    ptr_d          = ptr_q;
    cur_d          = cur_q;
    nxt_d          = nxt_q;
    valid_d        = valid_q;
    byte_d         = byte_q;
    sum_d          = sum_q;
    out_valid_d    = out_valid_q;
    digest_d       = digest_q;
    rd_en          = 1'b0;
    rd_addr        = nxt_q;
    wr_en          = 1'b0;
    mix_ctrl.start = 1'b0;

    // downstream drains the output register
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          byte_d = in_i.data_byte;
          if (in_i.restart) begin
            // restart empties the ring before this byte goes in
            valid_d = '0;
            ptr_d   = '0;
            cur_d   = '0;
            nxt_d   = ring_next('0);
          end else begin
            cur_d = ptr_q;
            nxt_d = ring_next(ptr_q);
          end
          state_d = S_RDC;
        end
      end
      S_RDC: begin
        // fetch the current word
        rd_en   = 1'b1;
        rd_addr = cur_q;
        state_d = S_INIT;
      end
      S_INIT: begin
        // seed the mixer, fetch the next word meanwhile
        mix_ctrl.start = 1'b1;
        rd_en          = 1'b1;
        rd_addr        = nxt_q;
        state_d        = S_MIX;
      end
      S_MIX: begin
        if (mix_stat.done) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        // fold mixed value into the next word and step the pointer
        sum_d          = rd_word + mix_result;
        wr_en          = 1'b1;
        valid_d[nxt_q] = 1'b1;
        ptr_d          = nxt_q;
        state_d        = S_RDN;
      end
      S_RDN: begin
        // word after the new pointer, for the digest
        rd_en   = 1'b1;
        rd_addr = nxt2;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          digest_d    = sum_q ^ rd_word;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        rd_ok_q <= valid_q[rd_addr];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    byte_q   <= byte_d;
    sum_q    <= sum_d;
    digest_q <= digest_d;
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[nxt_q] <= sum_d;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  ksrh_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mix_ctrl),
    .value_i  (mix_seed),
    .stat_o   (mix_stat),
    .result_o (mix_result)
  );

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.digest = digest_q;

  // mixer is only kicked off when it is free
  `KSRH_ASSERT(a_mix_start_free, mix_ctrl.start |-> !mix_stat.busy, "mixer started while busy")

  // a finished mix only shows up while the sequencer waits for it
  `KSRH_ASSERT(a_mix_done_waited, mix_stat.done |-> (state_q == S_MIX), "unexpected mix done")

  // an accepted restart leaves the ring empty and the pointer at zero
  `KSRH_ASSERT(a_restart_clears, (in_fire && in_i.restart) |=> (valid_q == '0 && ptr_q == '0),
               "restart did not clear the ring")

  // the pointer steps to the written word
  `KSRH_ASSERT(a_ptr_step, (state_q == S_ADD) |=> (ptr_q == $past(nxt_q) && valid_q[ptr_q]),
               "pointer did not follow the write")

  // the pointer never leaves the ring
  `KSRH_ASSERT(a_ptr_range, ptr_q <= LastIdx, "ring pointer out of range")

endmodule
